/* rtl/core/vfcm_pkg.sv */
// Package with shared types, codes and tables for the voxel face-culling mesher.
package vfcm_pkg;

	// Command codes carried on the cmd port
	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_MESH    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	localparam int unsigned IN_W     = 4;
	localparam int unsigned COORD_W  = 7;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned FACE_W   = 3;
	localparam int unsigned CORNER_W = 3;
	localparam int unsigned VIDX_W   = 17;
	localparam int unsigned PROBE_W  = 3;

	localparam logic [PROBE_W-1:0] NUM_PROBES  = 3'd7;
	localparam logic [FACE_W-1:0]  FACE_LAST   = 3'd5;
	localparam logic [1:0]         CORNER_LAST = 2'd3;
	localparam logic [VIDX_W-1:0]  COUNT_MAX   = 17'h1FFFF;

	// Corner numbers per face: bit2 high x, bit1 high y, bit0 high z
	localparam logic [CORNER_W-1:0] FACE_CORNER [6][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd5, 3'd1, 3'd4, 3'd0},
		'{3'd4, 3'd0, 3'd6, 3'd2},
		'{3'd1, 3'd5, 3'd3, 3'd7},
		'{3'd5, 3'd4, 3'd7, 3'd6},
		'{3'd6, 3'd2, 3'd7, 3'd3}
	};

	// Commands from controller to datapath
	typedef struct packed {
		logic                 accept;
		logic                 clear_step;
		logic                 probe_rd;
		logic [PROBE_W-1:0]   probe_sel;
		logic                 probe_cap;
		logic [PROBE_W-1:0]   cap_sel;
		logic                 emit_vtx;
		logic                 emit_none;
		logic [FACE_W-1:0]    face;
		logic [1:0]           corner;
		logic                 last;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic       clear_done;
		logic       center_solid;
		logic [5:0] vis_mask;
	} dp_stat_t;

endpackage

/* rtl/core/vfcm_ctrl.sv */
// Controller state machine: clearing pass, neighbor probe sequence and vertex emission.
module vfcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            cmd,
	input  vfcm_pkg::dp_stat_t    stat,
	output vfcm_pkg::ctrl_cmd_t   ctl,
	output logic                  busy
);
	import vfcm_pkg::*;

	state_t              state_q, state_d;
	logic [PROBE_W-1:0]  probe_q, probe_d;
	logic [FACE_W-1:0]   face_q, face_d;
	logic [1:0]          corner_q, corner_d;
	logic                accept;
	logic                any_vis;
	logic [5:0]          upper_vis;

	// Decode handshake and visibility summary
	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		any_vis   = stat.center_solid && (stat.vis_mask != 6'd0);
		upper_vis = stat.vis_mask >> (face_q + 3'd1);
	end

	// Drive datapath commands
	always_comb begin
		ctl            = '0;
		ctl.accept     = accept;
		ctl.clear_step = (state_q == ST_CLEAR);
		ctl.probe_rd   = (state_q == ST_READ) && (probe_q != NUM_PROBES);
		ctl.probe_sel  = probe_q;
		ctl.probe_cap  = (state_q == ST_READ) && (probe_q != 3'd0);
		ctl.cap_sel    = probe_q - 3'd1;
		ctl.emit_none  = (state_q == ST_EMIT) && !any_vis;
		ctl.emit_vtx   = (state_q == ST_EMIT) && any_vis && stat.vis_mask[face_q];
		ctl.face       = face_q;
		ctl.corner     = corner_q;
		ctl.last       = ctl.emit_none ||
			(ctl.emit_vtx && (corner_q == CORNER_LAST) && (upper_vis == 6'd0));
		busy           = (state_q != ST_IDLE);
	end

	// Select next state and counters
	always_comb begin
		state_d  = state_q;
		probe_d  = probe_q;
		face_d   = face_q;
		corner_d = corner_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && (cmd == CMD_MESH)) begin
					state_d = ST_READ;
					probe_d = 3'd0;
				end
			end
			ST_READ: begin
				probe_d = probe_q + 3'd1;
				if (probe_q == NUM_PROBES) begin
					state_d  = ST_EMIT;
					face_d   = 3'd0;
					corner_d = 2'd0;
				end
			end
			ST_EMIT: begin
				if (ctl.emit_none || ctl.last) begin
					state_d = ST_IDLE;
				end else if (ctl.emit_vtx && (corner_q != CORNER_LAST)) begin
					corner_d = corner_q + 2'd1;
				end else if (face_q == FACE_LAST) begin
					state_d = ST_IDLE;
				end else begin
					face_d   = face_q + 3'd1;
					corner_d = 2'd0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			probe_q  <= '0;
			face_q   <= '0;
			corner_q <= '0;
		end else begin
			state_q  <= state_d;
			probe_q  <= probe_d;
			face_q   <= face_d;
			corner_q <= corner_d;
		end
	end

endmodule

/* rtl/core/vfcm_dp.sv */
// Datapath: occupancy memory, neighbor probe capture, vertex counter and result registers.
module vfcm_dp #(
	parameter int CHUNK_SIDE = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vfcm_pkg::ctrl_cmd_t                   ctl,
	input  logic [1:0]                            cmd,
	input  logic [vfcm_pkg::IN_W-1:0]             vx,
	input  logic [vfcm_pkg::IN_W-1:0]             vy,
	input  logic [vfcm_pkg::IN_W-1:0]             vz,
	input  logic                                  solid,
	output vfcm_pkg::dp_stat_t                    stat,
	output logic                                  strobe,
	output logic                                  vertex_valid,
	output logic [vfcm_pkg::POS_W-1:0]            px_half,
	output logic [vfcm_pkg::POS_W-1:0]            py_half,
	output logic [vfcm_pkg::POS_W-1:0]            pz_half,
	output logic [vfcm_pkg::FACE_W-1:0]           face_id,
	output logic [vfcm_pkg::CORNER_W-1:0]         corner_id,
	output logic [vfcm_pkg::VIDX_W-1:0]           vertex_index,
	output logic                                  last
);
	import vfcm_pkg::*;

	localparam int DEPTH   = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
	localparam int AW      = $clog2(DEPTH);
	localparam int SIDE_SQ = CHUNK_SIDE * CHUNK_SIDE;
	localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(CHUNK_SIDE);

	function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c);
		return AW'(a) * AW'(SIDE_SQ) + AW'(b) * AW'(CHUNK_SIDE) + AW'(c);
	endfunction

	logic                 mem_q [DEPTH];
	logic [AW-1:0]        clr_addr_q;
	logic [IN_W-1:0]      x_q, y_q, z_q;
	logic [6:0]           occ_q;
	logic                 rd_data_s1;
	logic                 inb_s1;
	logic [VIDX_W-1:0]    count_q;

	logic [COORD_W-1:0]   wx, wy, wz;
	logic [COORD_W-1:0]   nx, ny, nz;
	logic                 w_inside;
	logic                 we;
	logic                 wdata;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic                 n_inside;
	logic [CORNER_W-1:0]  corner_c;

	// Decode write request and clearing sweep
	always_comb begin
		wx       = COORD_W'(vx);
		wy       = COORD_W'(vy);
		wz       = COORD_W'(vz);
		w_inside = (wx < SIDE_C) && (wy < SIDE_C) && (wz < SIDE_C);
		we       = ctl.clear_step || (ctl.accept && (cmd == CMD_WRITE) && w_inside);
		wdata    = ctl.clear_step ? 1'b0 : solid;
		waddr    = ctl.clear_step ? clr_addr_q : addr_of(wx, wy, wz);
	end

	// Form the probe coordinate: center, then neighbors in face order
	always_comb begin
		nx = COORD_W'(x_q);
		ny = COORD_W'(y_q);
		nz = COORD_W'(z_q);
		case (ctl.probe_sel)
			3'd1:    nx = COORD_W'(x_q) - 7'd1;
			3'd2:    ny = COORD_W'(y_q) - 7'd1;
			3'd3:    nz = COORD_W'(z_q) - 7'd1;
			3'd4:    nz = COORD_W'(z_q) + 7'd1;
			3'd5:    nx = COORD_W'(x_q) + 7'd1;
			3'd6:    ny = COORD_W'(y_q) + 7'd1;
			default: nx = COORD_W'(x_q);
		endcase
		// below zero wraps to a large value and fails the bound too
		n_inside = (nx < SIDE_C) && (ny < SIDE_C) && (nz < SIDE_C);
		raddr    = addr_of(nx, ny, nz);
	end

	// Occupancy memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.probe_rd) begin
			rd_data_s1 <= mem_q[raddr];
			inb_s1     <= n_inside;
		end
	end

	// Advance the clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (ctl.clear_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Hold mesh coordinates and probe results
	always_ff @(posedge clk) begin
		if (ctl.accept && (cmd == CMD_MESH)) begin
			x_q <= vx;
			y_q <= vy;
			z_q <= vz;
		end
		if (ctl.probe_cap) begin
			occ_q[ctl.cap_sel] <= rd_data_s1 & inb_s1;
		end
	end

	// Clear on restart, saturate on each emitted vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.accept && (cmd == CMD_RESTART)) begin
			count_q <= '0;
		end else if (ctl.emit_vtx && (count_q != COUNT_MAX)) begin
			count_q <= count_q + 17'd1;
		end
	end

	assign corner_c = FACE_CORNER[ctl.face][ctl.corner];

	// Register the result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl.emit_vtx || ctl.emit_none;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_vtx) begin
			vertex_valid <= 1'b1;
			px_half      <= POS_W'({x_q, 1'b0}) + (corner_c[2] ? 6'd2 : 6'd0);
			py_half      <= POS_W'({y_q, 1'b0}) + (corner_c[1] ? 6'd2 : 6'd0);
			pz_half      <= POS_W'({z_q, 1'b0}) + (corner_c[0] ? 6'd2 : 6'd0);
			face_id      <= ctl.face;
			corner_id    <= corner_c;
			vertex_index <= count_q;
			last         <= ctl.last;
		end else if (ctl.emit_none) begin
			vertex_valid <= 1'b0;
			px_half      <= '0;
			py_half      <= '0;
			pz_half      <= '0;
			face_id      <= '0;
			corner_id    <= '0;
			vertex_index <= '0;
			last         <= 1'b1;
		end
	end

	assign stat.clear_done   = (clr_addr_q == AW'(DEPTH - 1));
	assign stat.center_solid = occ_q[0];
	assign stat.vis_mask     = ~occ_q[6:1];

endmodule

/* rtl/core/voxel_face_culling_mesher.sv */
// Top level of the voxel face-culling mesher: controller plus datapath.
//
// After reset the block runs a clearing pass over all CHUNK_SIDE**3 entries
// (4096 at the default) of the occupancy memory, with busy high; commands are taken
// once busy falls. A transaction is accepted when start is high and busy is low.
// Write and restart commands give no result. A mesh command holds busy through
// a probe phase (seven single-bit reads through the one memory read port: the
// voxel and its six neighbors), then an emit phase that sends the vertices of each
// visible face in turn, passing over each hidden face before the last visible one;
// an empty or fully hidden voxel gives a single empty result. Each result is
// registered and appears in the cycle after it is formed, marked by strobe for
// exactly one cycle; the receiver cannot stall, so results must be taken as they
// come. The final result of a mesh command carries last.
module voxel_face_culling_mesher #(
	parameter int CHUNK_SIDE = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            cmd,
	input  logic [vfcm_pkg::IN_W-1:0]             vx,
	input  logic [vfcm_pkg::IN_W-1:0]             vy,
	input  logic [vfcm_pkg::IN_W-1:0]             vz,
	input  logic                                  solid,
	output logic                                  strobe,
	output logic                                  vertex_valid,
	output logic [vfcm_pkg::POS_W-1:0]            px_half,
	output logic [vfcm_pkg::POS_W-1:0]            py_half,
	output logic [vfcm_pkg::POS_W-1:0]            pz_half,
	output logic [vfcm_pkg::FACE_W-1:0]           face_id,
	output logic [vfcm_pkg::CORNER_W-1:0]         corner_id,
	output logic [vfcm_pkg::VIDX_W-1:0]           vertex_index,
	output logic                                  last
);
	import vfcm_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	vfcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	vfcm_dp #(
		.CHUNK_SIDE (CHUNK_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.vx           (vx),
		.vy           (vy),
		.vz           (vz),
		.solid        (solid),
		.stat         (stat),
		.strobe       (strobe),
		.vertex_valid (vertex_valid),
		.px_half      (px_half),
		.py_half      (py_half),
		.pz_half      (pz_half),
		.face_id      (face_id),
		.corner_id    (corner_id),
		.vertex_index (vertex_index),
		.last         (last)
	);

	// Results only follow a cycle of mesh work
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without preceding mesh work");

	// An empty result always closes its mesh command
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !vertex_valid) |-> (last && (vertex_index == '0)))
		else $error("empty result not marked last or carries an index");

	// A mesh command keeps the block busy
	a_mesh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_MESH)) |=> busy)
		else $error("mesh transaction did not raise busy");

	// Emission ends with last, which frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("block still busy after final result");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the voxel face-culling mesher: directed table, saturation run, random.
module tb;
	import vfcm_pkg::*;

	localparam int SIDE         = 16;
	localparam int LIMIT        = 1_000_000;
	localparam int SAT_MESHES   = 5465;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE       = 40;
	localparam int SCRIPT_ROWS  = 22;

	// Command code the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [VIDX_W-1:0] VTX_CEIL = 17'h1FFFF;

	typedef struct packed {
		logic                vld;
		logic [POS_W-1:0]    px;
		logic [POS_W-1:0]    py;
		logic [POS_W-1:0]    pz;
		logic [FACE_W-1:0]   face;
		logic [CORNER_W-1:0] corner;
		logic [VIDX_W-1:0]   idx;
		logic                lst;
	} vertex_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [IN_W-1:0] x;
		logic [IN_W-1:0] y;
		logic [IN_W-1:0] z;
		logic            s;
		logic            blank;
	} stim_row_t;

	// Result of a mesh command that shows no face
	localparam vertex_t NO_FACE = '{vld: 1'b0, px: 6'd0, py: 6'd0, pz: 6'd0,
		face: 3'd0, corner: 3'd0, idx: 17'd0, lst: 1'b1};

	// Face order -x,-y,-z,+z,+x,+y: neighbor offsets and corners per face
	localparam int DX [6] = '{-1, 0, 0, 0, 1, 0};
	localparam int DY [6] = '{0, -1, 0, 0, 0, 1};
	localparam int DZ [6] = '{0, 0, -1, 1, 0, 0};
	localparam logic [2:0] CORNERS [6][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd5, 3'd1, 3'd4, 3'd0},
		'{3'd4, 3'd0, 3'd6, 3'd2},
		'{3'd1, 3'd5, 3'd3, 3'd7},
		'{3'd5, 3'd4, 3'd7, 3'd6},
		'{3'd6, 3'd2, 3'd7, 3'd3}
	};

	// Directed transactions; blank rows expect the no-face result as typed
	localparam stim_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{CMD_MESH,    4'd0,  4'd0,  4'd0,  1'b0, 1'b1},
		'{CMD_MESH,    4'd15, 4'd15, 4'd15, 1'b0, 1'b1},
		'{CMD_WRITE,   4'd0,  4'd0,  4'd0,  1'b1, 1'b0},
		'{CMD_MESH,    4'd0,  4'd0,  4'd0,  1'b0, 1'b0},
		'{CMD_WRITE,   4'd15, 4'd15, 4'd15, 1'b1, 1'b0},
		'{CMD_MESH,    4'd15, 4'd15, 4'd15, 1'b1, 1'b0},
		'{CMD_UNUSED,  4'd15, 4'd15, 4'd15, 1'b0, 1'b0},
		'{CMD_MESH,    4'd15, 4'd15, 4'd15, 1'b0, 1'b0},
		'{CMD_RESTART, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0},
		'{CMD_MESH,    4'd15, 4'd15, 4'd15, 1'b0, 1'b0},
		'{CMD_WRITE,   4'd4,  4'd5,  4'd5,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd6,  4'd5,  4'd5,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd4,  4'd5,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd6,  4'd5,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd5,  4'd4,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd5,  4'd6,  1'b1, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd5,  4'd5,  1'b1, 1'b0},
		'{CMD_MESH,    4'd5,  4'd5,  4'd5,  1'b0, 1'b1},
		'{CMD_MESH,    4'd4,  4'd5,  4'd5,  1'b0, 1'b0},
		'{CMD_WRITE,   4'd5,  4'd5,  4'd5,  1'b0, 1'b0},
		'{CMD_MESH,    4'd5,  4'd5,  4'd5,  1'b0, 1'b1},
		'{CMD_MESH,    4'd5,  4'd5,  4'd6,  1'b0, 1'b0}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          cmd;
	logic [IN_W-1:0]     vx;
	logic [IN_W-1:0]     vy;
	logic [IN_W-1:0]     vz;
	logic                solid;
	logic                strobe;
	logic                vertex_valid;
	logic [POS_W-1:0]    px_half;
	logic [POS_W-1:0]    py_half;
	logic [POS_W-1:0]    pz_half;
	logic [FACE_W-1:0]   face_id;
	logic [CORNER_W-1:0] corner_id;
	logic [VIDX_W-1:0]   vertex_index;
	logic                last;

	// Mirror of the block's state
	logic                occ [SIDE*SIDE*SIDE];
	logic [VIDX_W-1:0]   vtx_count;

	vertex_t             vertices_due [$];
	logic [11:0]         hot_voxels [$];
	vertex_t             due;
	int                  mismatch_count = 0;
	int                  cycles = 0;

	voxel_face_culling_mesher i_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic voxel_solid(input int x, input int y, input int z);
		if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE)
			return 1'b0;
		return occ[(x * SIDE + y) * SIDE + z];
	endfunction

	// Update the mirrored state and queue the vertices one command produces
	function automatic void predict_command(input logic [1:0] op, input logic [3:0] x,
		input logic [3:0] y, input logic [3:0] z, input logic s, input logic blank);
		vertex_t    v;
		vertex_t    held;
		bit         have;
		logic [2:0] c;
		int         f;
		int         k;
		have = 0;
		held = NO_FACE;
		case (op)
			CMD_WRITE: occ[(int'(x) * SIDE + int'(y)) * SIDE + int'(z)] = s;
			CMD_RESTART: vtx_count = '0;
			CMD_MESH: begin
				if (voxel_solid(int'(x), int'(y), int'(z))) begin
					for (f = 0; f < 6; f++) begin
						if (!voxel_solid(int'(x) + DX[f], int'(y) + DY[f], int'(z) + DZ[f])) begin
							for (k = 0; k < 4; k++) begin
								c = CORNERS[f][k];
								v.vld    = 1'b1;
								v.px     = 6'(2 * int'(x) + 2 * int'(c[2]));
								v.py     = 6'(2 * int'(y) + 2 * int'(c[1]));
								v.pz     = 6'(2 * int'(z) + 2 * int'(c[0]));
								v.face   = 3'(f);
								v.corner = c;
								v.idx    = vtx_count;
								v.lst    = 1'b0;
								// hold the count at its ceiling
								if (vtx_count != VTX_CEIL)
									vtx_count = vtx_count + 1'b1;
								if (have && !blank)
									vertices_due.push_back(held);
								held = v;
								have = 1;
							end
						end
					end
				end
				if (blank)
					held = NO_FACE;
				held.lst = 1'b1;
				vertices_due.push_back(held);
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [3:0] pick_coord(input int base);
		if ($urandom_range(0, 3) == 0)
			return 4'($urandom_range(0, 15));
		return 4'(base + $urandom_range(0, 3));
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Idle for the requested gap with junk on the fields, then present one transaction
	task automatic send_command(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
		input logic [3:0] z, input logic s, input logic blank, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd   <= 2'($urandom);
			vx    <= 4'($urandom);
			vy    <= 4'($urandom);
			vz    <= 4'($urandom);
			solid <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= op;
		vx    <= x;
		vy    <= y;
		vz    <= z;
		solid <= s;
		do @(posedge clk); while (busy);
		predict_command(op, x, y, z, s, blank);
		if (op == CMD_WRITE && s) begin
			hot_voxels.push_back({x, y, z});
			if (hot_voxels.size() > 16)
				void'(hot_voxels.pop_front());
		end
	endtask

	// Stop sending until every queued vertex has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (vertices_due.size() != 0)
			@(posedge clk);
	endtask

	// Compare each strobed result with the oldest expected vertex
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (vertices_due.size() == 0) begin
				$error("vertex result with none expected");
				mismatch_count++;
			end else begin
				due = vertices_due.pop_front();
				check_field("vertex_valid", 32'(due.vld), 32'(vertex_valid));
				check_field("px_half", 32'(due.px), 32'(px_half));
				check_field("py_half", 32'(due.py), 32'(py_half));
				check_field("pz_half", 32'(due.pz), 32'(pz_half));
				check_field("face_id", 32'(due.face), 32'(face_id));
				check_field("corner_id", 32'(due.corner), 32'(corner_id));
				check_field("vertex_index", 32'(due.idx), 32'(vertex_index));
				check_field("last", 32'(due.lst), 32'(last));
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int         i;
		int         r;
		int         base;
		bit         calm;
		logic [1:0] op;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		logic       s;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = CMD_WRITE;
		vx     = '0;
		vy     = '0;
		vz     = '0;
		solid  = 1'b0;
		for (i = 0; i < SIDE * SIDE * SIDE; i++)
			occ[i] = 1'b0;
		vtx_count = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (i = 0; i < SCRIPT_ROWS; i++)
			send_command(SCRIPT[i].op, SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].z, SCRIPT[i].s,
				SCRIPT[i].blank, pick_gap(1'b0));
		wait_drained();

		// Mesh the lone corner voxel until the vertex count saturates
		send_command(CMD_RESTART, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 0);
		for (i = 0; i < SAT_MESHES; i++)
			send_command(CMD_MESH, 4'd0, 4'd0, 4'd0, 1'($urandom), 1'b0,
				($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0);
		send_command(CMD_RESTART, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0, 0);
		wait_drained();

		// Random traffic clustered so that writes and meshes meet
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 50) % 3) == 2;
			r    = $urandom_range(0, 99);
			base = 6 * $urandom_range(0, 2);
			x    = pick_coord(base);
			y    = pick_coord(base);
			z    = pick_coord(base);
			s    = 1'($urandom_range(0, 9) < 7);
			if (r < 40) begin
				op = CMD_WRITE;
			end else if (r < 88) begin
				op = CMD_MESH;
				if (hot_voxels.size() != 0 && $urandom_range(0, 9) < 6)
					{x, y, z} = hot_voxels[$urandom_range(0, hot_voxels.size() - 1)];
			end else if (r < 94) begin
				op = CMD_RESTART;
			end else begin
				op = CMD_UNUSED;
			end
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			send_command(op, x, y, z, s, 1'b0, pick_gap(calm));
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
